>>> hdl/sce_pkg.sv
`default_nettype none
package sce_pkg;

    // Field widths fixed by the stream format
    localparam int SIZE_W    = 13;
    localparam int ENERGY_W  = 25;
    localparam int COST_W    = 40;
    localparam int BESTCOL_W = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_idx_t;

    // Chosen predecessor of a pixel
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_NW   = 2'd1,
        DIR_N    = 2'd2,
        DIR_NE   = 2'd3
    } dir_t;

endpackage
`default_nettype wire

>>> hdl/sce_ifs.sv
`default_nettype none

// Configuration write channel
interface sce_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [sce_pkg::CFG_IDX_W-1:0] index;
    logic [sce_pkg::SIZE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// Pixel energy channel
interface sce_pix_if;
    logic                         valid;
    logic                         ready;
    logic [sce_pkg::ENERGY_W-1:0] energy;

    modport source (output valid, output energy, input ready);
    modport sink   (input valid, input energy, output ready);
endinterface

// Path cost result channel
interface sce_cost_if;
    logic                          valid;
    logic                          ready;
    logic [sce_pkg::COST_W-1:0]    path_cost;
    sce_pkg::dir_t                 back_direction;
    logic                          image_done;
    logic [sce_pkg::BESTCOL_W-1:0] best_column;
    logic [sce_pkg::COST_W-1:0]    best_cost;

    modport source (output valid, output path_cost, output back_direction,
                    output image_done, output best_column, output best_cost,
                    input ready);
    modport sink   (input valid, input path_cost, input back_direction,
                    input image_done, input best_column, input best_cost,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/seam_cumulative_energy_top.sv
// Each accepted word is registered in the compute stage, then in the output
// register; result back-pressure stalls both. One pixel per cycle otherwise,
// set by the row memory's two read ports (north and north-east) plus one
// write port, with same-cycle write forwarding. Reset: counters, running
// best, valid flags and size registers (640 x 480) clear at once; the row
// memory needs no clearing pass and is ready at once.
`default_nettype none
module seam_cumulative_energy_top #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    sce_cfg_if.sink     cfg,
    sce_pix_if.sink     pixel,
    sce_cost_if.source  result
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WD_W  = (($clog2(MAX_WIDTH + 1) > sce_pkg::SIZE_W) ?
                            $clog2(MAX_WIDTH + 1) : sce_pkg::SIZE_W) + 1;
    localparam int HD_W  = (($clog2(MAX_HEIGHT + 1) > sce_pkg::SIZE_W) ?
                            $clog2(MAX_HEIGHT + 1) : sce_pkg::SIZE_W) + 1;
    localparam logic [WD_W-1:0] MAX_W_D = WD_W'(MAX_WIDTH);
    localparam logic [HD_W-1:0] MAX_H_D = HD_W'(MAX_HEIGHT);

    // Configuration
    logic [sce_pkg::SIZE_W-1:0] width_reg;
    logic [sce_pkg::SIZE_W-1:0] height_reg;

    // Input side counters
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    // Row memory and its read data
    logic [sce_pkg::COST_W-1:0] row_mem [MAX_WIDTH];
    logic [sce_pkg::COST_W-1:0] rd_n_reg;
    logic [sce_pkg::COST_W-1:0] rd_ne_reg;

    // Compute stage
    logic                         s1_valid_reg;
    logic [sce_pkg::ENERGY_W-1:0] s1_energy_reg;
    logic [COL_W-1:0]             s1_col_reg;
    logic                         s1_first_row_reg;
    logic                         s1_ne_ok_reg;
    logic                         s1_last_row_reg;
    logic                         s1_done_reg;
    logic                         fwd_n_reg;
    logic                         fwd_ne_reg;
    logic [sce_pkg::COST_W-1:0]   fwd_data_reg;
    logic [sce_pkg::COST_W-1:0]   window_left_reg;
    logic [sce_pkg::COST_W-1:0]   rb_cost_reg;
    logic [COL_W-1:0]             rb_col_reg;

    // Output register
    logic                          out_valid_reg;
    logic [sce_pkg::COST_W-1:0]    out_cost_reg;
    sce_pkg::dir_t                 out_dir_reg;
    logic                          out_done_reg;
    logic [sce_pkg::BESTCOL_W-1:0] out_bcol_reg;
    logic [sce_pkg::COST_W-1:0]    out_bcost_reg;

    // Combinational signals
    logic [WD_W-1:0]            w_eff;
    logic [HD_W-1:0]            h_eff;
    logic [WD_W-1:0]            col_inc;
    logic [HD_W-1:0]            row_inc;
    logic                       row_end;
    logic                       last_row;
    logic                       done;
    logic [COL_W-1:0]           col_ne;
    logic                       accept;
    logic                       s1_adv;
    logic [COL_W-1:0]           col_next;
    logic [ROW_W-1:0]           row_next;
    logic [sce_pkg::COST_W-1:0] n_val;
    logic [sce_pkg::COST_W-1:0] ne_val;
    logic [sce_pkg::COST_W-1:0] best;
    logic [sce_pkg::COST_W-1:0] cost;
    sce_pkg::dir_t              dir;
    logic                       rb_hit;
    logic [sce_pkg::COST_W-1:0] rb_cost_upd;
    logic [COL_W-1:0]           rb_col_upd;

    // Clamp the configured sizes to the supported range
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WD_W'(1);
        else if (WD_W'(width_reg) > MAX_W_D)
            w_eff = MAX_W_D;
        else
            w_eff = WD_W'(width_reg);

        if (height_reg == '0)
            h_eff = HD_W'(1);
        else if (HD_W'(height_reg) > MAX_H_D)
            h_eff = MAX_H_D;
        else
            h_eff = HD_W'(height_reg);
    end

    // Position of the incoming word in the image
    assign col_inc  = WD_W'(col_reg) + WD_W'(1);
    assign row_inc  = HD_W'(row_reg) + HD_W'(1);
    assign row_end  = (col_inc >= w_eff);
    assign last_row = (row_inc >= h_eff);
    assign done     = row_end && last_row;
    assign col_ne   = col_reg + COL_W'(1);

    // Handshakes
    assign s1_adv      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign pixel.ready = !s1_valid_reg || s1_adv;
    assign accept      = pixel.valid && pixel.ready;
    assign cfg.ready   = 1'b1;

    // Advance the raster counters
    always_comb
    begin
        if (done)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (row_end)
        begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    // Add this pixel's energy to the cheapest predecessor, or alone on row 0
    always_comb
    begin
        n_val  = fwd_n_reg  ? fwd_data_reg : rd_n_reg;
        ne_val = fwd_ne_reg ? fwd_data_reg : rd_ne_reg;
        best   = n_val;
        dir    = sce_pkg::DIR_N;
        if (s1_col_reg != '0)
        begin
            best = window_left_reg;
            dir  = sce_pkg::DIR_NW;
            if (n_val < best)
            begin
                best = n_val;
                dir  = sce_pkg::DIR_N;
            end
        end
        if (s1_ne_ok_reg && (ne_val < best))
        begin
            best = ne_val;
            dir  = sce_pkg::DIR_NE;
        end
        if (s1_first_row_reg)
        begin
            cost = sce_pkg::COST_W'(s1_energy_reg);
            dir  = sce_pkg::DIR_NONE;
        end
        else
        begin
            cost = sce_pkg::COST_W'(s1_energy_reg) + best;
        end
    end

    // Track the least cost over the final row, leftmost on ties
    assign rb_hit      = s1_last_row_reg && ((s1_col_reg == '0) || (cost < rb_cost_reg));
    assign rb_cost_upd = rb_hit ? cost : rb_cost_reg;
    assign rb_col_upd  = rb_hit ? s1_col_reg : rb_col_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= sce_pkg::WIDTH_RESET;
            height_reg <= sce_pkg::HEIGHT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                sce_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg.data;
                sce_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg.data;
                default:                   ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            rb_cost_reg     <= '0;
            rb_col_reg      <= '0;
            window_left_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end

            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (s1_adv)
            begin
                window_left_reg <= n_val;
                if (s1_done_reg)
                begin
                    rb_cost_reg <= '0;
                    rb_col_reg  <= '0;
                end
                else
                begin
                    rb_cost_reg <= rb_cost_upd;
                    rb_col_reg  <= rb_col_upd;
                end
            end
        end
    end

    // Load the compute stage; capture a write that lands on a read address
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_energy_reg    <= pixel.energy;
            s1_col_reg       <= col_reg;
            s1_first_row_reg <= (row_reg == '0);
            s1_ne_ok_reg     <= !row_end;
            s1_last_row_reg  <= last_row;
            s1_done_reg      <= done;
            fwd_n_reg        <= s1_adv && (s1_col_reg == col_reg);
            fwd_ne_reg       <= s1_adv && (s1_col_reg == col_ne);
            fwd_data_reg     <= cost;
        end
    end

    // Row memory write port
    always_ff @(posedge clk)
    begin
        if (s1_adv)
            row_mem[s1_col_reg] <= cost;
    end

    // Row memory read ports: north and north-east of the incoming word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_n_reg  <= row_mem[col_reg];
            rd_ne_reg <= row_mem[col_ne];
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_cost_reg  <= cost;
            out_dir_reg   <= dir;
            out_done_reg  <= s1_done_reg;
            out_bcol_reg  <= s1_done_reg ? sce_pkg::BESTCOL_W'(rb_col_upd) : '0;
            out_bcost_reg <= s1_done_reg ? rb_cost_upd : '0;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.path_cost      = out_cost_reg;
    assign result.back_direction = out_dir_reg;
    assign result.image_done     = out_done_reg;
    assign result.best_column    = out_bcol_reg;
    assign result.best_cost      = out_bcost_reg;

endmodule
`default_nettype wire

>>> hdl/sce_checker.sv
`default_nettype none
module sce_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [sce_pkg::COST_W-1:0]    path_cost,
    input wire sce_pkg::dir_t                 back_direction,
    input wire logic                          image_done,
    input wire logic [sce_pkg::BESTCOL_W-1:0] best_column,
    input wire logic [sce_pkg::COST_W-1:0]    best_cost
);

    // Hold a stalled word
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    a_hold_cost: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(path_cost) && $stable(best_cost))
        else $error("result payload changed while stalled");

    // Best fields read zero except on the last pixel
    a_best_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !image_done |-> (best_cost == '0) && (best_column == '0))
        else $error("best fields set off the last pixel");

    // The last pixel is on the final row, so the best cannot exceed it
    a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_done |-> best_cost <= path_cost)
        else $error("best cost above last pixel cost");

    // A first-row pixel costs only its own energy
    a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (back_direction == sce_pkg::DIR_NONE) |->
            (path_cost >> sce_pkg::ENERGY_W) == '0)
        else $error("first-row cost exceeds energy range");

endmodule

bind seam_cumulative_energy_top sce_checker u_sce_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .path_cost      (result.path_cost),
    .back_direction (result.back_direction),
    .image_done     (result.image_done),
    .best_column    (result.best_column),
    .best_cost      (result.best_cost)
);
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
module tb;

    localparam int MAX_W = 4096;
    localparam int MAX_H = 4096;
    localparam logic [sce_pkg::ENERGY_W-1:0] ENERGY_TOP = 25'd18727200;
    localparam logic [sce_pkg::ENERGY_W-1:0] ENERGY_ALL = 25'h1FFFFFF;

    typedef struct {
        logic [sce_pkg::COST_W-1:0]    path_cost;
        sce_pkg::dir_t                 back_direction;
        logic                          image_done;
        logic [sce_pkg::BESTCOL_W-1:0] best_column;
        logic [sce_pkg::COST_W-1:0]    best_cost;
    } cost_word_t;

    logic clk = 1'b0;
    logic rst_n;

    sce_cfg_if  cfg_bus ();
    sce_pix_if  pix_bus ();
    sce_cost_if cost_bus ();

    seam_cumulative_energy_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .pixel  (pix_bus),
        .result (cost_bus)
    );

    // Pending pixel energies and the path costs they must produce
    logic [sce_pkg::ENERGY_W-1:0] energy_queue [$];
    cost_word_t                   cost_expect [$];

    int  error_count = 0;
    int  random_items = 0;
    bit  word_taken = 1'b0;
    int  send_gap = 0;
    int  send_calm = 0;
    int  recv_stall = 0;
    int  recv_calm = 0;

    // Seam predictor state
    logic [sce_pkg::SIZE_W-1:0] width_reg;
    logic [sce_pkg::SIZE_W-1:0] height_reg;
    bit [sce_pkg::COST_W-1:0]   row_mem [MAX_W];
    int unsigned                col_pos;
    int unsigned                row_pos;
    int unsigned                written_span;
    bit [sce_pkg::COST_W-1:0]   nw_cost;
    bit [sce_pkg::COST_W-1:0]   final_best_cost;
    int unsigned                final_best_col;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned clamp_dim(logic [sce_pkg::SIZE_W-1:0] v,
                                              int unsigned bound);
        if (v == 0)
            return 1;
        if (v > bound)
            return bound;
        return int'(v);
    endfunction

    // Advance the seam state by one pixel and queue the expected word
    task automatic predict_cost(input logic [sce_pkg::ENERGY_W-1:0] energy);
        int unsigned              w;
        int unsigned              h;
        int unsigned              c;
        bit                       row_end;
        bit                       last_row;
        bit                       done;
        bit                       have;
        bit [sce_pkg::COST_W-1:0] cost;
        bit [sce_pkg::COST_W-1:0] best;
        bit [sce_pkg::COST_W-1:0] mid;
        bit [sce_pkg::COST_W-1:0] ne;
        sce_pkg::dir_t            dir;
        cost_word_t               word;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        c = col_pos;
        row_end = (c + 1 >= w);
        last_row = (row_pos + 1 >= h);
        done = row_end && last_row;
        cost = sce_pkg::COST_W'(energy);
        dir = sce_pkg::DIR_NONE;
        if (c >= MAX_W)
            c = MAX_W - 1;
        mid = row_mem[c];
        if (row_pos != 0)
        begin
            best = '0;
            have = 1'b0;
            if (c > 0)
            begin
                best = nw_cost;
                dir = sce_pkg::DIR_NW;
                have = 1'b1;
            end
            if (!have || mid < best)
            begin
                best = mid;
                dir = sce_pkg::DIR_N;
            end
            if (c + 1 < w && c + 1 < MAX_W)
            begin
                ne = row_mem[c + 1];
                if (ne < best)
                begin
                    best = ne;
                    dir = sce_pkg::DIR_NE;
                end
            end
            cost = sce_pkg::COST_W'(energy) + best;
        end
        // Old column value becomes the next pixel's north-west
        nw_cost = mid;
        row_mem[c] = cost;
        if (c + 1 > written_span)
            written_span = c + 1;
        if (last_row && (c == 0 || cost < final_best_cost))
        begin
            final_best_cost = cost;
            final_best_col = c;
        end
        word.path_cost = cost;
        word.back_direction = dir;
        word.image_done = done;
        word.best_column = done ? final_best_col[sce_pkg::BESTCOL_W-1:0] : '0;
        word.best_cost = done ? final_best_cost : '0;
        cost_expect.push_back(word);
        if (done)
        begin
            col_pos = 0;
            row_pos = 0;
            final_best_cost = '0;
            final_best_col = 0;
            nw_cost = '0;
        end
        else if (row_end)
        begin
            col_pos = 0;
            row_pos++;
            nw_cost = '0;
        end
        else
            col_pos = c + 1;
    endtask

    // Pixels left until the current image ends, from the predictor's counters
    function automatic int unsigned pixels_to_finish();
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned n;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        c = col_pos;
        r = row_pos;
        n = 1;
        while (!(c + 1 >= w && r + 1 >= h))
        begin
            if (c + 1 >= w)
            begin
                r++;
                c = 0;
            end
            else
                c++;
            n++;
        end
        return n;
    endfunction

    // Idle length: mostly none or short, a few long, with calm stretches
    function automatic int draw_idle(ref int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = int'($urandom_range(0, 999));
        if (r < 10)
        begin
            calm = int'($urandom_range(40, 200));
            return 0;
        end
        if (r < 650)
            return 0;
        if (r < 900)
            return int'($urandom_range(1, 3));
        if (r < 980)
            return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 40));
    endfunction

    // Energy flavors: 0 few distinct values (ties), 1 spec range, 2 mixed
    function automatic logic [sce_pkg::ENERGY_W-1:0] draw_energy(int flavor);
        int r;
        if (flavor == 0)
            return sce_pkg::ENERGY_W'($urandom_range(0, 3));
        if (flavor == 1)
            return sce_pkg::ENERGY_W'($urandom_range(0, ENERGY_TOP));
        r = int'($urandom_range(0, 99));
        if (r < 5)
            return sce_pkg::ENERGY_W'($urandom_range(0, ENERGY_ALL));
        if (r < 10)
            return ENERGY_TOP;
        if (r < 15)
            return '0;
        if (r < 35)
            return sce_pkg::ENERGY_W'($urandom_range(0, 3));
        return sce_pkg::ENERGY_W'($urandom_range(0, ENERGY_TOP));
    endfunction

    task automatic queue_pixels(input int count, input int flavor);
        repeat (count)
            energy_queue.push_back(draw_energy(flavor));
    endtask

    task automatic write_reg(input sce_pkg::cfg_idx_t idx,
                             input logic [sce_pkg::SIZE_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        if (idx == sce_pkg::REG_IMAGE_WIDTH)
            width_reg = value;
        else
            height_reg = value;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Hold until every queued pixel is taken and every result is back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (energy_queue.size() != 0 || cost_expect.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    // Record an accepted pixel word
    always @(posedge clk)
    begin
        if (rst_n && pix_bus.valid && pix_bus.ready)
        begin
            predict_cost(pix_bus.energy);
            void'(energy_queue.pop_front());
            word_taken = 1'b1;
        end
    end

    // Drive the pixel channel: hold until taken, then idle or advance
    always @(negedge clk)
    begin
        if (!pix_bus.valid || word_taken)
        begin
            if (send_gap > 0)
            begin
                pix_bus.valid <= 1'b0;
                send_gap--;
            end
            else if (rst_n && energy_queue.size() != 0)
            begin
                pix_bus.valid  <= 1'b1;
                pix_bus.energy <= energy_queue[0];
                send_gap = draw_idle(send_calm);
            end
            else
                pix_bus.valid <= 1'b0;
        end
        word_taken = 1'b0;
    end

    // Stall the result channel at random
    always @(negedge clk)
    begin
        if (recv_stall > 0)
        begin
            cost_bus.ready <= 1'b0;
            recv_stall--;
        end
        else
        begin
            cost_bus.ready <= 1'b1;
            recv_stall = draw_idle(recv_calm);
        end
    end

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin : check_result
        cost_word_t want;
        if (rst_n && cost_bus.valid && cost_bus.ready)
        begin
            if (cost_expect.size() == 0)
            begin
                $error("result word with no pixel outstanding");
                error_count++;
            end
            else
            begin
                want = cost_expect.pop_front();
                if (cost_bus.path_cost !== want.path_cost)
                begin
                    $error("path_cost: expected %0d, got %0d",
                           want.path_cost, cost_bus.path_cost);
                    error_count++;
                end
                if (cost_bus.back_direction !== want.back_direction)
                begin
                    $error("back_direction: expected %0d, got %0d",
                           want.back_direction, cost_bus.back_direction);
                    error_count++;
                end
                if (cost_bus.image_done !== want.image_done)
                begin
                    $error("image_done: expected %0d, got %0d",
                           want.image_done, cost_bus.image_done);
                    error_count++;
                end
                if (cost_bus.best_column !== want.best_column)
                begin
                    $error("best_column: expected %0d, got %0d",
                           want.best_column, cost_bus.best_column);
                    error_count++;
                end
                if (cost_bus.best_cost !== want.best_cost)
                begin
                    $error("best_cost: expected %0d, got %0d",
                           want.best_cost, cost_bus.best_cost);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int flavor;
        int r;
        int images;
        int unsigned full;
        int unsigned part;
        int unsigned rest;
        int unsigned span_cap;
        logic [sce_pkg::SIZE_W-1:0] w_val;
        logic [sce_pkg::SIZE_W-1:0] h_val;

        rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = sce_pkg::REG_IMAGE_WIDTH;
        cfg_bus.data = '0;
        pix_bus.valid = 1'b0;
        pix_bus.energy = '0;
        cost_bus.ready = 1'b0;
        width_reg = sce_pkg::WIDTH_RESET;
        height_reg = sce_pkg::HEIGHT_RESET;
        col_pos = 0;
        row_pos = 0;
        written_span = 0;
        nw_cost = '0;
        final_best_cost = '0;
        final_best_col = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // 3x3: extreme energies, every direction, ties in all positions
        write_reg(sce_pkg::REG_IMAGE_WIDTH, 13'd3);
        write_reg(sce_pkg::REG_IMAGE_HEIGHT, 13'd3);
        energy_queue = {ENERGY_ALL, 25'd0, ENERGY_TOP,
                        25'd5, 25'd5, 25'd5,
                        25'd0, 25'd0, 25'd0};
        wait_drained();

        // 4x2: best column away from the left edge, leftmost of a tie
        write_reg(sce_pkg::REG_IMAGE_WIDTH, 13'd4);
        write_reg(sce_pkg::REG_IMAGE_HEIGHT, 13'd2);
        energy_queue = {25'd9, 25'd9, 25'd9, 25'd9,
                        25'd7, 25'd3, 25'd8, 25'd3};
        wait_drained();

        // Single column: north only
        write_reg(sce_pkg::REG_IMAGE_WIDTH, 13'd1);
        write_reg(sce_pkg::REG_IMAGE_HEIGHT, 13'd2);
        energy_queue = {ENERGY_TOP, ENERGY_ALL};
        wait_drained();

        // Zero sizes count as one: every pixel is a whole image
        write_reg(sce_pkg::REG_IMAGE_WIDTH, 13'd0);
        write_reg(sce_pkg::REG_IMAGE_HEIGHT, 13'd0);
        energy_queue = {25'h0AAAAAA, 25'h1555555};
        wait_drained();

        // Oversized width saturates; shrink it mid-row
        write_reg(sce_pkg::REG_IMAGE_WIDTH, 13'd8191);
        write_reg(sce_pkg::REG_IMAGE_HEIGHT, 13'd3);
        queue_pixels(10, 2);
        wait_drained();
        write_reg(sce_pkg::REG_IMAGE_WIDTH, 13'd6);
        queue_pixels(pixels_to_finish(), 2);
        wait_drained();

        // Oversized height saturates; shrink it mid-image
        write_reg(sce_pkg::REG_IMAGE_WIDTH, 13'd1);
        write_reg(sce_pkg::REG_IMAGE_HEIGHT, 13'd8191);
        queue_pixels(6, 2);
        wait_drained();
        write_reg(sce_pkg::REG_IMAGE_HEIGHT, 13'd2);
        queue_pixels(pixels_to_finish(), 2);
        wait_drained();

        // Random images, small sizes dominating
        while (random_items < 550)
        begin
            flavor = int'($urandom_range(0, 2));
            r = int'($urandom_range(0, 99));
            if (r < 5)
                w_val = 13'd0;
            else if (r < 80)
                w_val = sce_pkg::SIZE_W'($urandom_range(1, 12));
            else if (r < 95)
                w_val = sce_pkg::SIZE_W'($urandom_range(13, 64));
            else
                w_val = sce_pkg::SIZE_W'($urandom_range(65, 160));
            r = int'($urandom_range(0, 99));
            if (r < 5)
                h_val = 13'd0;
            else if (r < 85 || w_val > 64)
                h_val = sce_pkg::SIZE_W'($urandom_range(1, 3 + 3 * (w_val <= 64)));
            else
                h_val = sce_pkg::SIZE_W'($urandom_range(7, 12));
            if ($urandom_range(0, 1))
            begin
                write_reg(sce_pkg::REG_IMAGE_WIDTH, w_val);
                write_reg(sce_pkg::REG_IMAGE_HEIGHT, h_val);
            end
            else
            begin
                write_reg(sce_pkg::REG_IMAGE_HEIGHT, h_val);
                write_reg(sce_pkg::REG_IMAGE_WIDTH, w_val);
            end
            full = pixels_to_finish();
            if (full > 1 && $urandom_range(0, 4) == 0)
            begin
                // Resize partway through; grow only over written columns
                part = $urandom_range(1, full - 1);
                queue_pixels(part, flavor);
                wait_drained();
                if ($urandom_range(0, 1))
                begin
                    span_cap = (written_span < 64) ? written_span : 64;
                    write_reg(sce_pkg::REG_IMAGE_WIDTH,
                              sce_pkg::SIZE_W'($urandom_range(0, span_cap)));
                end
                else
                    write_reg(sce_pkg::REG_IMAGE_HEIGHT,
                              sce_pkg::SIZE_W'($urandom_range(0, 10)));
                rest = pixels_to_finish();
                queue_pixels(rest, flavor);
                random_items += part + rest;
            end
            else
            begin
                images = int'($urandom_range(1, 3));
                queue_pixels(full * images, flavor);
                random_items += full * images;
            end
            wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> seam_cumulative_energy_top.f
hdl/sce_pkg.sv
hdl/sce_ifs.sv
hdl/seam_cumulative_energy_top.sv
hdl/sce_checker.sv
tb/tb.sv
